// ===== rtl/core/drm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix resampler package
// Shared widths, register map, state encoding and controller interface types.
// ============================================================================
package drm_pkg;

  // Default sample width of the mono stream (Q1.15).
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Number of channel lanes on the input item.
  localparam int MAX_CH = 8;
  localparam int CHC_W  = 4;

  // Block length, position and count widths.
  localparam int LEN_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = 24;
  localparam int POS_W   = 34;
  localparam int CNT_W   = 22;

  // Smallest usable ratio is 1/32 in Q16.16.
  localparam logic [RATIO_W-1:0] MIN_RATIO = RATIO_W'(2048);

  // Output count divider: dividend is the block length in Q16.16. With the
  // ratio at least 2^11 the quotient never needs more than 21 bits.
  localparam int DVD_W     = LEN_W + FRAC_W;
  localparam int DIV_STEPS = 21;
  localparam int DIV_PRE   = DVD_W - DIV_STEPS;

  // Most results one input item may cause.
  localparam int MAX_RESULTS = 64;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // Configuration port.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_RATE_RATIO    = 1'b1;

  localparam logic [CHC_W-1:0]   CHANNEL_COUNT_RST = CHC_W'(2);
  localparam logic [RATIO_W-1:0] RATE_RATIO_RST    = RATIO_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_FIX,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sum;
    logic mul;
    logic fix;
    logic emit;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic more;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/drm_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Output count divider
// Restoring divider, one quotient bit per cycle, for block length over ratio.
// ============================================================================
module drm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [drm_pkg::DVD_W-1:0]      dividend_i,
  input  logic [drm_pkg::RATIO_W-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [drm_pkg::DIV_STEPS-1:0]  quot_o
);
  import drm_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

  logic [CNT_BITS-1:0]  cnt_q;
  logic [RATIO_W-1:0]   rem_q;
  logic [RATIO_W-1:0]   dsr_q;
  logic [DIV_STEPS-1:0] shf_q;

  logic [RATIO_W:0]     cat;
  logic [RATIO_W+1:0]   trial;
  logic                 borrow;

  assign cat    = {rem_q, shf_q[DIV_STEPS-1]};
  assign trial  = {1'b0, cat} - {2'b00, dsr_q};
  assign borrow = trial[RATIO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_BITS'(DIV_STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // The top bits of the dividend are always below the divisor.
      rem_q <= RATIO_W'(dividend_i[DVD_W-1 -: DIV_PRE]);
      shf_q <= dividend_i[DIV_STEPS-1:0];
      dsr_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= borrow ? cat[RATIO_W-1:0] : trial[RATIO_W-1:0];
      shf_q <= {shf_q[DIV_STEPS-2:0], ~borrow};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = shf_q;

endmodule

// ===== rtl/core/drm_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix resampler datapath
// Channel clamp and average, output count, interpolation and result register.
// ============================================================================
module drm_dp #(
  parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [drm_pkg::CHC_W-1:0]        channel_count_i,
  input  logic [drm_pkg::RATIO_W-1:0]      rate_ratio_i,
  input  logic signed [SAMPLE_WIDTH+1:0]   ch_samples_i [drm_pkg::MAX_CH],
  input  logic [drm_pkg::LEN_W-1:0]        block_frames_i,
  input  drm_pkg::dp_cmd_t                 cmd_i,
  output drm_pkg::dp_status_t              status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample_o,
  output logic                             run_last_o,
  output logic                             block_last_o
);
  import drm_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int IN_W  = SW + 2;
  localparam int SUM_W = SW + $clog2(MAX_CH);
  localparam int MW    = SUM_W;
  localparam int QD_W  = MW + 1 + CHC_W;
  localparam int PI_W  = POS_W - FRAC_W;
  localparam int SMAX  = (1 << (SW - 1)) - 1;
  localparam int SMIN  = -SMAX - 1;
  localparam logic signed [IN_W-1:0] CLIP_HI = IN_W'(SMAX);
  localparam logic signed [IN_W-1:0] CLIP_LO = IN_W'(SMIN);

  // Reciprocal table: floor(2^MW / d), so the estimate is at most one short.
  logic [MW:0] recip_tab [MAX_CH+1];
  for (genvar g = 0; g <= MAX_CH; g++) begin : g_recip
    localparam int DIV_G = (g == 0) ? 1 : g;
    localparam logic [MW:0] RC = (MW+1)'((64'd1 << MW) / DIV_G);
    assign recip_tab[g] = RC;
  end

  // --------------------------------------------------------------------------
  // Pipeline and frame state
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]    lane_q [MAX_CH];
  logic [CHC_W-1:0]        chn_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    neg_q;
  logic [MW-1:0]           mag_q;
  logic [2*MW:0]           prod_q;
  logic signed [SW-1:0]    mono_q;
  logic signed [SW-1:0]    prev_q;
  logic [LEN_W-1:0]        frame_idx_q;
  logic [LEN_W-1:0]        len_q;
  logic [LEN_W-1:0]        k_q;
  logic                    last_q;
  logic [POS_W-1:0]        pos_q;
  logic [CNT_W-1:0]        emitted_q;
  logic [NRES_W-1:0]       n_q;
  logic [RATIO_W-1:0]      r_used_q;
  logic                    out_valid_q;
  logic signed [SW-1:0]    out_sample_q;
  logic                    run_last_q;
  logic                    block_last_q;

  // --------------------------------------------------------------------------
  // Load side
  // --------------------------------------------------------------------------
  logic [CHC_W-1:0]   chn_c;
  logic [RATIO_W-1:0] r_eff;
  logic [LEN_W-1:0]   len_new;
  logic               first_c;
  logic               last_c;
  logic               need_div;
  logic signed [SW-1:0] lane_c [MAX_CH];

  always_comb begin
    if (channel_count_i == '0) begin
      chn_c = CHC_W'(1);
    end else if (channel_count_i > CHC_W'(MAX_CH)) begin
      chn_c = CHC_W'(MAX_CH);
    end else begin
      chn_c = channel_count_i;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CH; i++) begin
      if (CHC_W'(i) >= chn_c) begin
        lane_c[i] = '0;
      end else if (ch_samples_i[i] > CLIP_HI) begin
        lane_c[i] = CLIP_HI[SW-1:0];
      end else if (ch_samples_i[i] < CLIP_LO) begin
        lane_c[i] = CLIP_LO[SW-1:0];
      end else begin
        lane_c[i] = ch_samples_i[i][SW-1:0];
      end
    end
  end

  assign r_eff    = (rate_ratio_i < MIN_RATIO) ? MIN_RATIO : rate_ratio_i;
  assign first_c  = (frame_idx_q == '0);
  assign len_new  = first_c ? ((block_frames_i == '0) ? LEN_W'(1) : block_frames_i) : len_q;
  assign last_c   = ({1'b0, frame_idx_q} + (LEN_W+1)'(1)) >= {1'b0, len_new};
  assign need_div = first_c || (r_eff != r_used_q);

  // --------------------------------------------------------------------------
  // Output count
  // --------------------------------------------------------------------------
  logic                 div_busy;
  logic [DIV_STEPS-1:0] quot;
  logic [CNT_W-1:0]     count_c;

  drm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load && need_div),
    .dividend_i ({len_new, FRAC_W'(0)}),
    .divisor_i  (r_eff),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign count_c = (quot == '0) ? CNT_W'(1) : CNT_W'(quot);

  // --------------------------------------------------------------------------
  // Average: sum, reciprocal multiply, one-step correction
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_c;
  logic [MW-1:0]           mag_c;
  logic [2*MW:0]           prod_c;
  logic [MW:0]             q0;
  logic [QD_W-1:0]         q0d;
  logic [QD_W-1:0]         rem_c;
  logic [MW:0]             q_c;
  logic [MW:0]             sq_c;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < MAX_CH; i++) begin
      sum_c = sum_c + SUM_W'(lane_q[i]);
    end
  end

  assign mag_c  = sum_q[SUM_W-1] ? MW'(-sum_q) : MW'(sum_q);
  assign prod_c = mag_c * recip_tab[chn_q];
  assign q0     = prod_q[2*MW:MW];
  assign q0d    = q0 * chn_q;
  assign rem_c  = QD_W'(mag_q) - q0d;
  assign q_c    = (rem_c >= QD_W'(chn_q)) ? q0 + (MW+1)'(1) : q0;
  assign sq_c   = neg_q ? -q_c : q_c;

  // --------------------------------------------------------------------------
  // Emission
  // --------------------------------------------------------------------------
  logic [PI_W-1:0]               pos_int;
  logic [PI_W-1:0]               k_ext;
  logic [POS_W-1:0]              pos_n;
  logic [CNT_W-1:0]              em_n;
  logic [NRES_W-1:0]             n_n;
  logic                          sel_interp;
  logic                          more_c;
  logic                          more_after;
  logic signed [SW:0]            diff_c;
  logic signed [SW+FRAC_W+1:0]   prodi_c;
  logic signed [SW+FRAC_W+1:0]   shf_c;
  logic signed [SW-1:0]          interp_c;
  logic signed [SW-1:0]          value_c;

  assign pos_int    = pos_q[POS_W-1:FRAC_W];
  assign k_ext      = PI_W'(k_q);
  assign pos_n      = pos_q + POS_W'(r_used_q);
  assign em_n       = emitted_q + CNT_W'(1);
  assign n_n        = n_q + NRES_W'(1);
  assign sel_interp = (pos_int < k_ext);

  // A result is due while the block count is not reached, the per-item cap
  // is not hit, and either its right neighbour has arrived or this is the
  // block's last frame.
  assign more_c     = (emitted_q < count_c) && (n_q < NRES_W'(MAX_RESULTS)) &&
                      (last_q || sel_interp);
  assign more_after = (em_n < count_c) && (n_n < NRES_W'(MAX_RESULTS)) &&
                      (last_q || (pos_n[POS_W-1:FRAC_W] < k_ext));

  // a + floor((b - a) * f / 2^16) equals floor((a*(1-f) + b*f) / 2^16).
  assign diff_c   = (SW+1)'(mono_q) - (SW+1)'(prev_q);
  assign prodi_c  = diff_c * $signed({1'b0, pos_q[FRAC_W-1:0]});
  assign shf_c    = prodi_c >>> FRAC_W;
  assign interp_c = prev_q + shf_c[SW-1:0];
  assign value_c  = sel_interp ? interp_c : mono_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_idx_q <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      emitted_q   <= '0;
      n_q         <= '0;
      r_used_q    <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (first_c) begin
          len_q     <= len_new;
          pos_q     <= '0;
          emitted_q <= '0;
        end
        frame_idx_q <= last_c ? '0 : frame_idx_q + LEN_W'(1);
        n_q         <= '0;
        if (need_div) begin
          r_used_q <= r_eff;
        end
      end
      if (cmd_i.emit) begin
        pos_q     <= pos_n;
        emitted_q <= em_n;
        n_q       <= n_n;
      end
      if (cmd_i.finish) begin
        prev_q <= mono_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lane_q <= lane_c;
      chn_q  <= chn_c;
      k_q    <= frame_idx_q;
      last_q <= last_c;
    end
    if (cmd_i.sum) begin
      sum_q <= sum_c;
    end
    if (cmd_i.mul) begin
      neg_q  <= sum_q[SUM_W-1];
      mag_q  <= mag_c;
      prod_q <= prod_c;
    end
    if (cmd_i.fix) begin
      mono_q <= SW'(sq_c);
    end
    if (cmd_i.emit) begin
      out_sample_q <= value_c;
      run_last_q   <= ~more_after;
      block_last_q <= (em_n == count_c);
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.more     = more_c;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign run_last_o   = run_last_q;
  assign block_last_o = block_last_q;

endmodule

// ===== rtl/core/drm_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix resampler controller
// Sequences the average, waits for the output count and paces the results.
// ============================================================================
module drm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drm_pkg::dp_status_t status_i,
  output drm_pkg::dp_cmd_t    cmd_o
);
  import drm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        // The output count must be settled before any decision is taken.
        if (!status_i.div_busy) begin
          if (!status_i.more) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/downmix_linear_resampler_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix linear resampler
// Averages up to eight channels into mono and resamples by linear
// interpolation at a programmable Q16.16 ratio.
// ============================================================================
// Each input item is one multichannel frame of a block. The used channels are
// clamped to signed Q1.15, averaged with truncation toward zero, and the mono
// stream is resampled: output i of a block sits at input position i * ratio
// and a block gives max(1, floor(length / ratio)) outputs, the last ones
// repeating the block's final sample. An item is accepted and its lanes clamped,
// then passes the adder tree, the reciprocal multiply and its correction
// step, then gives one result per cycle while the output register is free,
// and a closing step ends it. On the first frame of a block, and on the first
// frame after the ratio has been changed, the output count is recomputed by a
// restoring divider that yields one quotient bit a cycle; it is started when
// the item is accepted and the results then wait for it. Results leave through
// an output register, so the next item can be accepted while the last result
// of the previous one is still waiting to be taken. Configuration registers
// are channel_count at byte address 0 and rate_ratio at byte address 4; they
// should be written only while no item is in flight.
// ============================================================================
module downmix_linear_resampler_unit #(
  parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [drm_pkg::ADDR_W-1:0]        paddr,
  input  logic [drm_pkg::DATA_W-1:0]        pwdata,
  output logic [drm_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,

  // Input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch0_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch1_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch2_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch3_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch4_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch5_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch6_sample_i,
  input  logic signed [SAMPLE_WIDTH+1:0]    ch7_sample_i,
  input  logic [drm_pkg::LEN_W-1:0]         block_frames_i,

  // Result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_o,
  output logic                              run_last_o,
  output logic                              block_last_o
);
  import drm_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; the port
  // never inserts wait states.
  // --------------------------------------------------------------------------
  logic [CHC_W-1:0]   channel_count_q;
  logic [RATIO_W-1:0] rate_ratio_q;
  logic               cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CHANNEL_COUNT_RST;
      rate_ratio_q    <= RATE_RATIO_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CHANNEL_COUNT: channel_count_q <= pwdata[CHC_W-1:0];
        REG_RATE_RATIO:    rate_ratio_q    <= pwdata[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count_q);
      REG_RATE_RATIO:    prdata = DATA_W'(rate_ratio_q);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Channel lanes gathered for the datapath.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH+1:0] ch_samples [MAX_CH];

  assign ch_samples[0] = ch0_sample_i;
  assign ch_samples[1] = ch1_sample_i;
  assign ch_samples[2] = ch2_sample_i;
  assign ch_samples[3] = ch3_sample_i;
  assign ch_samples[4] = ch4_sample_i;
  assign ch_samples[5] = ch5_sample_i;
  assign ch_samples[6] = ch6_sample_i;
  assign ch_samples[7] = ch7_sample_i;

  // --------------------------------------------------------------------------
  // Controller and datapath
  // --------------------------------------------------------------------------
  dp_cmd_t    cmd;
  dp_status_t status;

  drm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  drm_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (channel_count_q),
    .rate_ratio_i    (rate_ratio_q),
    .ch_samples_i    (ch_samples),
    .block_frames_i  (block_frames_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_sample_o    (out_sample_o),
    .run_last_o      (run_last_o),
    .block_last_o    (block_last_o)
  );

endmodule

// ===== verif/downmix_linear_resampler_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix resampler output checker
// Watches the configuration port and both item channels of the resampler,
// predicts every result from the accepted frames and compares field by field.
// ============================================================================
module downmix_linear_resampler_checker #(
  parameter int SAMPLE_WIDTH = drm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,

  input  logic                                            cfg_sel_i,
  input  logic                                            cfg_enable_i,
  input  logic                                            cfg_write_i,
  input  logic                                            cfg_ready_i,
  input  logic [drm_pkg::ADDR_W-1:0]                      cfg_addr_i,
  input  logic [drm_pkg::DATA_W-1:0]                      cfg_wdata_i,

  input  logic                                            in_valid_i,
  input  logic                                            in_ready_i,
  input  logic [drm_pkg::MAX_CH-1:0][SAMPLE_WIDTH+1:0]    ch_samples_i,
  input  logic [drm_pkg::LEN_W-1:0]                       block_frames_i,

  input  logic                                            out_valid_i,
  input  logic                                            out_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                  out_sample_i,
  input  logic                                            run_last_i,
  input  logic                                            block_last_i,

  output int                                              mismatches_o,
  output int                                              outstanding_o,
  output int                                              outputs_o,
  output int                                              frames_o,
  output int                                              blocks_o
);

  localparam int Q_TOP    = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int Q_BOTTOM = -(2 ** (SAMPLE_WIDTH - 1));

  localparam logic [drm_pkg::ADDR_W-1:0] ADDR_CHANNELS = {drm_pkg::REG_CHANNEL_COUNT, 2'b00};
  localparam logic [drm_pkg::ADDR_W-1:0] ADDR_RATIO    = {drm_pkg::REG_RATE_RATIO, 2'b00};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           run_last;
    logic                           block_last;
  } mono_out_t;

  // Shadow copies of the registers and of the resampler state.
  logic [drm_pkg::CHC_W-1:0]   channels_reg;
  logic [drm_pkg::RATIO_W-1:0] ratio_reg;
  int                          prev_mono;
  int                          frame_pos;
  int                          block_len;
  logic [drm_pkg::POS_W-1:0]   position;
  int                          emitted;

  mono_out_t due_outputs[$];
  mono_out_t want;
  int        mismatches;
  int        outputs_seen;
  int        frames_seen;
  int        blocks_seen;

  function automatic logic signed [SAMPLE_WIDTH-1:0] interpolate_pair(
    input int left, input int right, input logic [drm_pkg::FRAC_W-1:0] frac);
    longint                         acc;
    logic signed [SAMPLE_WIDTH-1:0] res;
    acc = longint'(left) * (longint'(65536) - longint'(frac)) + longint'(right) * longint'(frac);
    res = acc >>> drm_pkg::FRAC_W;
    return res;
  endfunction

  // Downmixes one frame and queues every output sample that it releases.
  task automatic downmix_and_resample(
    input logic [drm_pkg::MAX_CH-1:0][SAMPLE_WIDTH+1:0] chans,
    input logic [drm_pkg::LEN_W-1:0]                    frames);
    mono_out_t batch [drm_pkg::MAX_RESULTS];
    int        used;
    int        sample_v;
    int        mono;
    int        step;
    int        total;
    int        n;
    int        k;
    bit        at_end;
    longint    acc;
    used = (channels_reg == 0) ? 1 :
           (channels_reg > drm_pkg::MAX_CH) ? drm_pkg::MAX_CH : int'(channels_reg);
    acc  = 0;
    for (int i = 0; i < used; i++) begin
      sample_v = $signed(chans[i]);
      if (sample_v > Q_TOP) sample_v = Q_TOP;
      else if (sample_v < Q_BOTTOM) sample_v = Q_BOTTOM;
      acc += sample_v;
    end
    mono = int'(acc / used);

    if (frame_pos == 0) begin
      block_len = (frames == 0) ? 1 : int'(frames);
      position  = '0;
      emitted   = 0;
    end

    step  = (ratio_reg < drm_pkg::MIN_RATIO) ? int'(drm_pkg::MIN_RATIO) : int'(ratio_reg);
    total = int'((longint'(block_len) << drm_pkg::FRAC_W) / step);
    if (total == 0) total = 1;
    k      = frame_pos;
    at_end = (k + 1 >= block_len);
    n      = 0;

    if (k > 0) begin
      while (emitted < total && (position >> drm_pkg::FRAC_W) < k &&
             n < drm_pkg::MAX_RESULTS) begin
        batch[n].sample     = interpolate_pair(prev_mono, mono,
                                               position[drm_pkg::FRAC_W-1:0]);
        batch[n].run_last   = 1'b0;
        batch[n].block_last = (emitted + 1 == total);
        n++;
        emitted++;
        position += step;
      end
    end
    // The final frame pads the block out with its own sample.
    if (at_end) begin
      while (emitted < total && n < drm_pkg::MAX_RESULTS) begin
        batch[n].sample     = mono;
        batch[n].run_last   = 1'b0;
        batch[n].block_last = (emitted + 1 == total);
        n++;
        emitted++;
        position += step;
      end
    end
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) batch[j].run_last = 1'b1;
      due_outputs.push_back(batch[j]);
    end

    prev_mono = mono;
    frame_pos = at_end ? 0 : k + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_reg = drm_pkg::CHANNEL_COUNT_RST;
      ratio_reg    = drm_pkg::RATE_RATIO_RST;
      prev_mono    = 0;
      frame_pos    = 0;
      block_len    = 0;
      position     = '0;
      emitted      = 0;
      mismatches   = 0;
      outputs_seen = 0;
      frames_seen  = 0;
      blocks_seen  = 0;
      due_outputs.delete();
    end else begin
      if (cfg_sel_i && cfg_enable_i && cfg_write_i && cfg_ready_i) begin
        if (cfg_addr_i == ADDR_CHANNELS) channels_reg = cfg_wdata_i[drm_pkg::CHC_W-1:0];
        else if (cfg_addr_i == ADDR_RATIO) ratio_reg = cfg_wdata_i[drm_pkg::RATIO_W-1:0];
      end

      if (in_valid_i && in_ready_i) begin
        frames_seen++;
        downmix_and_resample(ch_samples_i, block_frames_i);
      end

      if (out_valid_i && out_ready_i) begin
        outputs_seen++;
        if (block_last_i) blocks_seen++;
        if (due_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: expected no output, got sample %0d run_last %0b block_last %0b",
                   $time, out_sample_i, run_last_i, block_last_i);
        end else begin
          want = due_outputs.pop_front();
          if (out_sample_i !== want.sample) begin
            mismatches++;
            $display("%0t: out_sample expected %0d, got %0d", $time, want.sample, out_sample_i);
          end
          if (run_last_i !== want.run_last) begin
            mismatches++;
            $display("%0t: run_last expected %0b, got %0b", $time, want.run_last, run_last_i);
          end
          if (block_last_i !== want.block_last) begin
            mismatches++;
            $display("%0t: block_last expected %0b, got %0b",
                     $time, want.block_last, block_last_i);
          end
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= due_outputs.size();
    outputs_o     <= outputs_seen;
    frames_o      <= frames_seen;
    blocks_o      <= blocks_seen;
  end

endmodule

// ===== verif/downmix_linear_resampler_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Downmix linear resampler testbench
// Drives multichannel frames and register settings into the resampler while
// both handshakes idle at random; a checker beside the block predicts and
// compares every output item.
// ============================================================================
module downmix_linear_resampler_unit_test;

  import drm_pkg::*;

  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int IN_W            = SW + 2;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  // Long enough for the divider, a full run of results and the output register
  // to drain once nothing more is expected.
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 19;
  localparam int PRESSURE_PHASE  = 8;
  localparam int HOLD_CYCLES     = 500;
  localparam int LIMIT_CYCLES    = 500000;

  localparam int RATIO_UNITY = 65536;
  localparam int RATIO_TOP   = 2 ** RATIO_W - 1;

  localparam logic signed [IN_W-1:0] IN_TOP    = 2 ** (IN_W - 1) - 1;
  localparam logic signed [IN_W-1:0] IN_BOTTOM = -(2 ** (IN_W - 1));
  localparam logic signed [IN_W-1:0] Q_TOP     = 2 ** (SW - 1) - 1;
  localparam logic signed [IN_W-1:0] Q_BOTTOM  = -(2 ** (SW - 1));

  localparam logic [ADDR_W-1:0] ADDR_CHANNELS = {REG_CHANNEL_COUNT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_RATIO    = {REG_RATE_RATIO, 2'b00};

  typedef logic [MAX_CH-1:0][IN_W-1:0] chans_t;

  // Every block input starts at a known value.
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [ADDR_W-1:0]       paddr          = '0;
  logic [DATA_W-1:0]       pwdata         = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  ch0_sample_i   = '0;
  logic signed [IN_W-1:0]  ch1_sample_i   = '0;
  logic signed [IN_W-1:0]  ch2_sample_i   = '0;
  logic signed [IN_W-1:0]  ch3_sample_i   = '0;
  logic signed [IN_W-1:0]  ch4_sample_i   = '0;
  logic signed [IN_W-1:0]  ch5_sample_i   = '0;
  logic signed [IN_W-1:0]  ch6_sample_i   = '0;
  logic signed [IN_W-1:0]  ch7_sample_i   = '0;
  logic [LEN_W-1:0]        block_frames_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic signed [SW-1:0]    out_sample_o;
  logic                    run_last_o;
  logic                    block_last_o;

  // Figures handed up by the checker.
  int mismatches;
  int outstanding;
  int outputs_seen;
  int frames_seen;
  int blocks_seen;

  // Stimulus control shared between the processes.
  int               send_idle_pct = 27;
  int               recv_idle_pct = 76;
  bit               hold_req      = 1'b0;
  int               frames_left   = 0;
  logic [LEN_W-1:0] cur_len       = '0;
  int               settings_applied = 0;
  int               cycle_count   = 0;

  downmix_linear_resampler_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch0_sample_i   (ch0_sample_i),
    .ch1_sample_i   (ch1_sample_i),
    .ch2_sample_i   (ch2_sample_i),
    .ch3_sample_i   (ch3_sample_i),
    .ch4_sample_i   (ch4_sample_i),
    .ch5_sample_i   (ch5_sample_i),
    .ch6_sample_i   (ch6_sample_i),
    .ch7_sample_i   (ch7_sample_i),
    .block_frames_i (block_frames_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_o   (out_sample_o),
    .run_last_o     (run_last_o),
    .block_last_o   (block_last_o)
  );

  downmix_linear_resampler_checker #(.SAMPLE_WIDTH(SW)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_sel_i      (psel),
    .cfg_enable_i   (penable),
    .cfg_write_i    (pwrite),
    .cfg_ready_i    (pready),
    .cfg_addr_i     (paddr),
    .cfg_wdata_i    (pwdata),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .ch_samples_i   ({ch7_sample_i, ch6_sample_i, ch5_sample_i, ch4_sample_i,
                      ch3_sample_i, ch2_sample_i, ch1_sample_i, ch0_sample_i}),
    .block_frames_i (block_frames_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_i   (out_sample_o),
    .run_last_i     (run_last_o),
    .block_last_i   (block_last_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .outputs_o      (outputs_seen),
    .frames_o       (frames_seen),
    .blocks_o       (blocks_seen)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: a run that is still going at the limit has lost items somewhere.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped at %0d cycles with %0d outputs still expected",
             cycle_count, outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver. It takes outputs at the rate the current stretch asks for. When
  // the stimulus requests a hold-off, it keeps ready low for a long, counted
  // stretch so that the output register fills and the input side backs up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Builds a frame whose even channels carry one value and odd channels another.
  function automatic chans_t fill(input logic [IN_W-1:0] even_v, input logic [IN_W-1:0] odd_v);
    chans_t c;
    for (int i = 0; i < MAX_CH; i++) c[i] = (i % 2 == 0) ? even_v : odd_v;
    return c;
  endfunction

  // Random frame. Samples mix the clamp boundaries, values just past them,
  // ordinary Q1.15 values and arbitrary 18-bit patterns, so every bit of every
  // lane is exercised and clamping happens often.
  function automatic chans_t rand_chans();
    chans_t c;
    for (int i = 0; i < MAX_CH; i++) begin
      case ($urandom_range(0, 9))
        0:       c[i] = IN_TOP;
        1:       c[i] = IN_BOTTOM;
        2:       c[i] = Q_TOP;
        3:       c[i] = Q_BOTTOM;
        4:       c[i] = Q_TOP + 1;
        5:       c[i] = Q_BOTTOM - 1;
        6, 7:    c[i] = $urandom_range(0, 2 ** SW - 1) - 2 ** (SW - 1);
        default: c[i] = $urandom();
      endcase
    end
    return c;
  endfunction

  // Offers one frame and waits for it to be accepted. The frame counter tracks
  // block boundaries: the length field of a block's first frame decides how
  // many frames belong to it, a zero length meaning a single frame. Valid is
  // only lowered when the sender actually idles, never between two frames
  // that follow each other directly.
  task automatic offer_frame(input chans_t chans, input logic [LEN_W-1:0] frames);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    ch0_sample_i   <= chans[0];
    ch1_sample_i   <= chans[1];
    ch2_sample_i   <= chans[2];
    ch3_sample_i   <= chans[3];
    ch4_sample_i   <= chans[4];
    ch5_sample_i   <= chans[5];
    ch6_sample_i   <= chans[6];
    ch7_sample_i   <= chans[7];
    block_frames_i <= frames;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (frames_left == 0) begin
      cur_len     = frames;
      frames_left = (frames == 0) ? 1 : int'(frames);
    end
    frames_left--;
  endtask

  // Brings the block to rest: every expected output has been taken, and then
  // enough cycles have passed for a frame that causes no output (and may still
  // be in the divider) to finish as well.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One configuration write: setup cycle, then access cycle until pready. The
  // port is released for a cycle afterwards so that back-to-back writes never
  // lower and raise psel within the same step.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes both registers. Half the writes carry junk in the unused upper bits,
  // which the block must ignore.
  task automatic program_unit(input int chans_n, input int ratio);
    logic [DATA_W-1:0] word;
    word = $urandom_range(0, 1) ? $urandom() : '0;
    word[CHC_W-1:0] = chans_n;
    write_reg(ADDR_CHANNELS, word);
    word = $urandom_range(0, 1) ? $urandom() : '0;
    word[RATIO_W-1:0] = ratio;
    write_reg(ADDR_RATIO, word);
    settings_applied++;
  endtask

  initial begin
    int               chans_n;
    int               ratio;
    logic [LEN_W-1:0] field;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part ---------------------------------------------------
    // Reset values: two channels at unity ratio, so the mono samples pass
    // through unchanged. The first frame clamps both extremes and averages
    // them to zero; the last is a block of zero length, treated as one frame,
    // whose average of -3 and 0 must truncate toward zero.
    offer_frame(fill(IN_TOP, IN_BOTTOM), LEN_W'(4));
    offer_frame(fill(IN_TOP, IN_TOP), LEN_W'(4));
    offer_frame(fill(IN_BOTTOM, IN_BOTTOM), LEN_W'(4));
    offer_frame(fill(Q_TOP, Q_BOTTOM + 1), LEN_W'(4));
    offer_frame(fill(-3, 0), LEN_W'(0));

    // All eight channels averaged.
    settle();
    program_unit(MAX_CH, RATIO_UNITY);
    repeat (2) offer_frame(rand_chans(), LEN_W'(2));

    // A zero channel count means one channel; the smallest ratio upsamples by
    // 32, so the last frame releases the full 64 outputs at once.
    settle();
    program_unit(0, MIN_RATIO);
    offer_frame(fill(Q_TOP, 0), LEN_W'(2));
    offer_frame(fill(Q_BOTTOM, 0), LEN_W'(2));

    // A count above eight is held at eight and a zero ratio at the minimum.
    settle();
    program_unit(2 ** CHC_W - 1, 0);
    offer_frame(rand_chans(), LEN_W'(1));

    // The largest ratio gives a single output; later frames of the block
    // cause none.
    settle();
    program_unit(1, RATIO_TOP);
    repeat (3) offer_frame(rand_chans(), LEN_W'(3));

    // Ratio changed in the middle of a block, from upsampling to downsampling.
    settle();
    program_unit(4, RATIO_UNITY / 2);
    repeat (3) offer_frame(rand_chans(), LEN_W'(6));
    settle();
    program_unit(4, RATIO_UNITY * 2);
    repeat (3) offer_frame(rand_chans(), LEN_W'(6));

    // Ratio raised mid-block past the point where the count is already met:
    // the rest of the block stays silent and no block end is flagged.
    settle();
    program_unit(3, RATIO_UNITY / 4);
    repeat (2) offer_frame(rand_chans(), LEN_W'(4));
    settle();
    program_unit(3, RATIO_TOP);
    repeat (2) offer_frame(rand_chans(), LEN_W'(4));

    // ---- Random part -----------------------------------------------------
    // Each phase picks a fresh setting at rest, then streams well-formed
    // blocks with random content. Blocks run across phase boundaries, so
    // later settings also land in the middle of blocks.
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 27;
      end else if (phase == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(0, 5))
        0:       chans_n = 0;
        1:       chans_n = 1;
        2:       chans_n = MAX_CH;
        3:       chans_n = 2 ** CHC_W - 1;
        default: chans_n = $urandom_range(0, 2 ** CHC_W - 1);
      endcase
      case ($urandom_range(0, 9))
        0:       ratio = MIN_RATIO;
        1:       ratio = $urandom_range(0, MIN_RATIO - 1);
        2:       ratio = RATIO_UNITY;
        3:       ratio = RATIO_TOP;
        4, 5:    ratio = $urandom_range(MIN_RATIO, RATIO_UNITY);
        6, 7:    ratio = $urandom_range(RATIO_UNITY, 4 * RATIO_UNITY);
        8:       ratio = $urandom_range(0, RATIO_TOP);
        default: ratio = $urandom_range(MIN_RATIO, 4 * MIN_RATIO);
      endcase
      settle();
      program_unit(chans_n, ratio);

      // The sender keeps offering while the receiver stalls for a long time.
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        if (frames_left == 0) begin
          case ($urandom_range(0, 99)) inside
            [0:7]:   field = 0;
            [8:19]:  field = 1;
            [20:69]: field = $urandom_range(2, 8);
            [70:94]: field = $urandom_range(9, 40);
            default: field = $urandom_range(41, 120);
          endcase
        end else begin
          // The length field is only read on a block's first frame; later
          // frames mostly repeat it and sometimes carry junk.
          field = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom()) : cur_len;
        end
        offer_frame(rand_chans(), field);
      end
    end

    settle();

    $display("Covered %0d frames, %0d finished blocks and %0d outputs over %0d settings.",
             frames_seen, blocks_seen, outputs_seen, settings_applied);
    $display("%0d mismatches after %0d cycles.", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
